>>> hdl/assert_macros.svh
// assertion helpers shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/ssc_pkg.sv
`default_nettype none
package ssc_pkg;

   // paren depth counter and reported depth
   localparam int DEPTH_BITS = 16;
   localparam int PAREN_W    = 16;

   typedef logic [DEPTH_BITS-1:0] depth_type;
   typedef logic [PAREN_W-1:0]    paren_type;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [7:0] MARKER_RESET = 8'd59;

   typedef enum logic [0:0] {
      REG_COMMENT_MARKER = 1'b0
   } reg_index_type;

   // character codes
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_VT     = 8'h0b;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_EXTRA_CLOSE = 3'd1,
      ERR_BAD_ESCAPE  = 3'd2,
      ERR_UNBALANCED  = 3'd3,
      ERR_OVERFLOW    = 3'd4
   } err_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_char;
      paren_type  paren_depth;
      logic       expr_end;
      err_type    error_code;
      logic       last;
   } rsp_type;

   // results handed from the scan stage to the result buffer
   typedef struct packed {
      logic    valid;
      logic    two;
      rsp_type r0;
      rsp_type r1;
   } load_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage
`default_nettype wire

>>> hdl/sexpr_stream_scanner.sv
// S-expression stream scanner: takes one text byte per req transaction and returns
// the byte after escape translation with the open paren depth, an expression-end
// flag and an error code; comments and held backslashes come back as results with
// has_char low. A byte is accepted every cycle while the result buffer has room
// and its result reaches the rsp port through the input register, then the result
// register; the one exception is an escaped quote, which returns two results and
// holds the input register while the two-entry result buffer drains. The
// comment marker is set through the csr port at byte address 0 and resets to ';'.
// end_of_stream reports an unbalanced input and returns the scanner to its reset
// state. No clearing pass follows reset.
`default_nettype none
module sexpr_stream_scanner (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input transactions
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_in_byte,
   input  wire logic                              req_end_of_stream,
   // result transactions
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [7:0]                        rsp_out_byte,
   output logic                                   rsp_has_char,
   output logic      [ssc_pkg::PAREN_W-1:0]       rsp_paren_depth,
   output logic                                   rsp_expr_end,
   output logic      [2:0]                        rsp_error_code,
   output logic                                   rsp_last,
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ssc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ssc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ssc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   logic              [7:0] marker;
   logic                    buf_free;
   ssc_pkg::load_type       load;
   ssc_pkg::rsp_type        rsp;

   // configuration register
   ssc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .marker  (marker)
   );

   // scan stage
   ssc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .marker            (marker),
      .buf_free          (buf_free),
      .load              (load)
   );

   // result buffer
   ssc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .buf_free  (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte    = rsp.out_byte;
   assign rsp_has_char    = rsp.has_char;
   assign rsp_paren_depth = rsp.paren_depth;
   assign rsp_expr_end    = rsp.expr_end;
   assign rsp_error_code  = rsp.error_code;
   assign rsp_last        = rsp.last;

endmodule
`default_nettype wire

>>> hdl/ssc_csr.sv
`default_nettype none
module ssc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ssc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [ssc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [ssc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                    pready,
   output logic      [7:0]                         marker
);

   logic [7:0] marker_ff;
   logic [7:0] marker_in;
   logic       hit;

   // register index sits above the byte offset
   assign hit = (paddr[ssc_pkg::CSR_ADDR_W-1] == ssc_pkg::REG_COMMENT_MARKER);

   always_comb begin
      marker_in = marker_ff;
      if (psel && penable && pwrite && hit) begin
         marker_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= ssc_pkg::MARKER_RESET;
      end else begin
         marker_ff <= marker_in;
      end
   end

   // read back
   assign prdata = hit ? {{(ssc_pkg::CSR_DATA_W-8){1'b0}}, marker_ff} : '0;
   assign pready = 1'b1;
   assign marker = marker_ff;

endmodule
`default_nettype wire

>>> hdl/ssc_core.sv
`default_nettype none
`include "assert_macros.svh"
module ssc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_end_of_stream,
   input  wire logic [7:0]        marker,
   input  wire logic              buf_free,
   output ssc_pkg::load_type      load
);

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_ESCAPE  = 2'd3
   } mode_type;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               in_eos_ff, in_eos_in;
   mode_type           mode_ff, mode_in;
   ssc_pkg::depth_type depth_ff, depth_in;
   logic               nonblank_ff, nonblank_in;
   logic               halted_ff, halted_in;

   logic               advance;
   logic               pass;
   logic               two;
   logic [7:0]         pass_byte;
   ssc_pkg::err_type   err;
   logic               seen;
   logic               eend;
   ssc_pkg::paren_type rep_depth;

   // input register frees when its transaction moves on to the result buffer
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || buf_free;

   // mode and depth update for the held byte
   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      halted_in = halted_ff;
      pass      = 1'b0;
      two       = 1'b0;
      pass_byte = in_byte_ff;
      err       = ssc_pkg::ERR_NONE;
      if (in_eos_ff) begin
         if (!halted_ff && ((depth_ff != '0) || (mode_ff == MODE_QUOTED) ||
                            (mode_ff == MODE_ESCAPE))) begin
            err = ssc_pkg::ERR_UNBALANCED;
         end
         mode_in   = MODE_NORMAL;
         depth_in  = '0;
         halted_in = 1'b0;
      end else if (!halted_ff) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (in_byte_ff == ssc_pkg::CH_OPEN) begin
                  if (depth_ff == '1) begin
                     halted_in = 1'b1;
                     err       = ssc_pkg::ERR_OVERFLOW;
                  end else begin
                     depth_in = depth_ff + ssc_pkg::depth_type'(1);
                     pass     = 1'b1;
                  end
               end else if (in_byte_ff == ssc_pkg::CH_CLOSE) begin
                  if (depth_ff == '0) begin
                     halted_in = 1'b1;
                     err       = ssc_pkg::ERR_EXTRA_CLOSE;
                  end else begin
                     depth_in = depth_ff - ssc_pkg::depth_type'(1);
                     pass     = 1'b1;
                  end
               end else if (in_byte_ff == ssc_pkg::CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
                  pass    = 1'b1;
               end else if (in_byte_ff == marker) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  pass = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (in_byte_ff == ssc_pkg::CH_NL) begin
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_QUOTED: begin
               if (in_byte_ff == ssc_pkg::CH_QUOTE) begin
                  mode_in = MODE_NORMAL;
                  pass    = 1'b1;
               end else if (in_byte_ff == ssc_pkg::CH_BSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  pass = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               if (in_byte_ff == ssc_pkg::CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
                  two     = 1'b1;
               end else if (in_byte_ff == ssc_pkg::CH_LOW_T) begin
                  mode_in   = MODE_QUOTED;
                  pass_byte = ssc_pkg::CH_TAB;
                  pass      = 1'b1;
               end else if (in_byte_ff == ssc_pkg::CH_LOW_N) begin
                  mode_in   = MODE_QUOTED;
                  pass_byte = ssc_pkg::CH_NL;
                  pass      = 1'b1;
               end else if ((in_byte_ff == marker) ||
                            (in_byte_ff == ssc_pkg::CH_BSLASH)) begin
                  mode_in = MODE_QUOTED;
                  pass    = 1'b1;
               end else begin
                  halted_in = 1'b1;
                  err       = ssc_pkg::ERR_BAD_ESCAPE;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase
      end
   end

   // expression end and non-blank tracking
   always_comb begin
      seen        = nonblank_ff || !ssc_pkg::is_blank(pass_byte);
      eend        = pass && (depth_in == '0) && (mode_in == MODE_NORMAL) && seen;
      nonblank_in = nonblank_ff;
      if (in_eos_ff) begin
         nonblank_in = 1'b0;
      end else if (two) begin
         nonblank_in = 1'b1;
      end else if (pass) begin
         nonblank_in = seen && !eend;
      end
   end

   // end of stream reports the depth before the restart
   assign rep_depth = in_eos_ff ? ssc_pkg::paren_type'(depth_ff)
                                : ssc_pkg::paren_type'(depth_in);

   // results; an escaped quote gives the backslash and then the quote
   always_comb begin
      load.valid          = advance;
      load.two            = two;
      load.r0.out_byte    = two ? ssc_pkg::CH_BSLASH : (pass ? pass_byte : 8'h00);
      load.r0.has_char    = pass || two;
      load.r0.paren_depth = rep_depth;
      load.r0.expr_end    = eend;
      load.r0.error_code  = err;
      load.r0.last        = !two;
      load.r1.out_byte    = ssc_pkg::CH_QUOTE;
      load.r1.has_char    = 1'b1;
      load.r1.paren_depth = rep_depth;
      load.r1.expr_end    = 1'b0;
      load.r1.error_code  = ssc_pkg::ERR_NONE;
      load.r1.last        = 1'b1;
   end

   // input register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eos_in   = in_eos_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_in_byte;
            in_eos_in  = req_end_of_stream;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         depth_ff    <= '0;
         nonblank_ff <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            depth_ff    <= depth_in;
            nonblank_ff <= nonblank_in;
            halted_ff   <= halted_in;
         end
      end
      in_byte_ff <= in_byte_in;
      in_eos_ff  <= in_eos_in;
   end

   // checks
   `ASSERT_ALWAYS(a_err_drops, clock, reset, (load.valid && (load.r0.error_code != ssc_pkg::ERR_NONE)) |-> (!load.r0.has_char && !load.r0.expr_end && load.r0.last), "error result carries a character")
   `ASSERT_ALWAYS(a_pair_order, clock, reset, (load.valid && load.two) |-> (!load.r0.last && load.r0.has_char && !load.r0.expr_end), "escaped quote pair malformed")
   `ASSERT_ALWAYS(a_halt_sticky, clock, reset, halted_ff |=> (halted_ff || $past(advance && in_eos_ff)), "halt cleared without end of stream")

endmodule
`default_nettype wire

>>> hdl/ssc_rsp_buf.sv
`default_nettype none
`include "assert_macros.svh"
module ssc_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ssc_pkg::load_type load,
   output logic                   buf_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ssc_pkg::rsp_type       rsp
);

   ssc_pkg::rsp_type slot0_ff, slot0_in;
   ssc_pkg::rsp_type slot1_ff, slot1_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;

   assign pop      = (cnt_ff != 2'd0) && rsp_ready;
   assign buf_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   // load a fresh pair or shift the second slot forward
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (load.valid) begin
         slot0_in = load.r0;
         slot1_in = load.r1;
         cnt_in   = load.two ? 2'd2 : 2'd1;
      end else if (pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp       = slot0_ff;

   // checks
   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff == 2'd3, "result count out of range")
   `ASSERT_ALWAYS(a_last_pending, clock, reset, (rsp_valid && !slot0_ff.last) |-> (cnt_ff == 2'd2), "non-final result without a follower")
   `ASSERT_ALWAYS(a_pair_drain, clock, reset, ((cnt_ff == 2'd2) && rsp_ready) |=> ((cnt_ff == 2'd1) && slot0_ff.last), "second result lost")

endmodule
`default_nettype wire

>>> tb/sv/tb_sexpr_stream_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sexpr_stream_scanner;

   typedef enum logic [1:0] {
      SCAN_NORMAL  = 2'd0,
      SCAN_COMMENT = 2'd1,
      SCAN_QUOTED  = 2'd2,
      SCAN_ESCAPE  = 2'd3
   } scan_mode_type;

   // tracks the scanner state and holds the results each accepted byte should produce
   class paren_scan_checker;
      logic [7:0]         marker;
      scan_mode_type      mode;
      ssc_pkg::depth_type depth;
      bit                 nonblank;
      bit                 halted;
      ssc_pkg::rsp_type   pending_results[$];
      int                 mismatches;
      int                 bytes_seen;
      int                 results_seen;
      int                 expr_ends_seen;
      int                 error_counts[8];
      ssc_pkg::depth_type deepest;

      function new();
         marker  = ssc_pkg::MARKER_RESET;
         deepest = '0;
         restart();
      endfunction

      function void restart();
         mode     = SCAN_NORMAL;
         depth    = '0;
         nonblank = 1'b0;
         halted   = 1'b0;
      endfunction

      function bit whitespace(logic [7:0] c);
         return c == ssc_pkg::CH_SPACE || c == ssc_pkg::CH_TAB || c == ssc_pkg::CH_NL ||
                c == ssc_pkg::CH_VT || c == ssc_pkg::CH_FF || c == ssc_pkg::CH_CR;
      endfunction

      function void push(logic [7:0] ch, bit has, bit eend, ssc_pkg::err_type err,
                         bit lst);
         ssc_pkg::rsp_type r;
         r.out_byte    = has ? ch : 8'h00;
         r.has_char    = has;
         r.paren_depth = ssc_pkg::paren_type'(depth);
         r.expr_end    = eend;
         r.error_code  = err;
         r.last        = lst;
         if (err != ssc_pkg::ERR_NONE) error_counts[err]++;
         pending_results = {pending_results, r};
      endfunction

      // a passed character, with the expression-end decision
      function void pass_char(logic [7:0] ch, bit lst);
         bit eend;
         if (!whitespace(ch)) nonblank = 1'b1;
         eend = (depth == '0) && (mode == SCAN_NORMAL) && nonblank;
         if (eend) nonblank = 1'b0;
         push(ch, 1'b1, eend, ssc_pkg::ERR_NONE, lst);
      endfunction

      function void note_byte(logic [7:0] c, logic eos);
         ssc_pkg::err_type err;
         bytes_seen++;
         if (eos) begin
            err = (!halted && (depth != '0 || mode == SCAN_QUOTED || mode == SCAN_ESCAPE)) ?
                  ssc_pkg::ERR_UNBALANCED : ssc_pkg::ERR_NONE;
            push(8'h00, 1'b0, 1'b0, err, 1'b1);
            restart();
            return;
         end
         if (halted) begin
            push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_NONE, 1'b1);
            return;
         end
         case (mode)
            SCAN_NORMAL: begin
               if (c == ssc_pkg::CH_OPEN) begin
                  if (depth == '1) begin
                     halted = 1'b1;
                     push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_OVERFLOW, 1'b1);
                     return;
                  end
                  depth++;
                  if (depth > deepest) deepest = depth;
               end else if (c == ssc_pkg::CH_CLOSE) begin
                  if (depth == '0) begin
                     halted = 1'b1;
                     push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_EXTRA_CLOSE, 1'b1);
                     return;
                  end
                  depth--;
               end else if (c == ssc_pkg::CH_QUOTE) begin
                  mode = SCAN_QUOTED;
               end else if (c == marker) begin
                  mode = SCAN_COMMENT;
                  push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_NONE, 1'b1);
                  return;
               end
               pass_char(c, 1'b1);
            end
            SCAN_COMMENT: begin
               if (c == ssc_pkg::CH_NL) mode = SCAN_NORMAL;
               push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_NONE, 1'b1);
            end
            SCAN_QUOTED: begin
               if (c == ssc_pkg::CH_BSLASH) begin
                  mode = SCAN_ESCAPE;
                  push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_NONE, 1'b1);
                  return;
               end
               if (c == ssc_pkg::CH_QUOTE) mode = SCAN_NORMAL;
               pass_char(c, 1'b1);
            end
            default: begin
               // escaped quote passes both bytes
               if (c == ssc_pkg::CH_QUOTE) begin
                  pass_char(ssc_pkg::CH_BSLASH, 1'b0);
                  mode = SCAN_QUOTED;
                  pass_char(ssc_pkg::CH_QUOTE, 1'b1);
                  return;
               end
               if (c == ssc_pkg::CH_LOW_T) begin
                  c = ssc_pkg::CH_TAB;
               end else if (c == ssc_pkg::CH_LOW_N) begin
                  c = ssc_pkg::CH_NL;
               end else if (c != marker && c != ssc_pkg::CH_BSLASH) begin
                  halted = 1'b1;
                  push(8'h00, 1'b0, 1'b0, ssc_pkg::ERR_BAD_ESCAPE, 1'b1);
                  return;
               end
               mode = SCAN_QUOTED;
               pass_char(c, 1'b1);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s mismatch, expected %0h, actual %0h",
                        $time, name, want_v, got_v);
         end
      endfunction

      function void check_result(ssc_pkg::rsp_type got);
         ssc_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: result with nothing pending, expected none, actual %h",
                        $time, got);
            return;
         end
         want = pending_results.pop_front();
         results_seen++;
         if (got.expr_end === 1'b1) expr_ends_seen++;
         compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
         compare_field("has_char", 16'(want.has_char), 16'(got.has_char));
         compare_field("paren_depth", 16'(want.paren_depth), 16'(got.paren_depth));
         compare_field("expr_end", 16'(want.expr_end), 16'(got.expr_end));
         compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid         = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_in_byte       = 8'h00;
   logic                           req_end_of_stream = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready         = 1'b0;
   logic [7:0]                     rsp_out_byte;
   logic                           rsp_has_char;
   logic [ssc_pkg::PAREN_W-1:0]    rsp_paren_depth;
   logic                           rsp_expr_end;
   logic [2:0]                     rsp_error_code;
   logic                           rsp_last;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [ssc_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [ssc_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [ssc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   paren_scan_checker sb = new();
   ssc_pkg::rsp_type  observed;
   logic [7:0]        chunk_bytes[$];
   int                send_idle_pct = 0;
   int                rsp_idle_pct  = 0;
   int                hold_cycles   = 0;
   bit                hold_trigger  = 1'b0;

   sexpr_stream_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_char      (rsp_has_char),
      .rsp_paren_depth   (rsp_paren_depth),
      .rsp_expr_end      (rsp_expr_end),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   assign observed = {rsp_out_byte, rsp_has_char, rsp_paren_depth, rsp_expr_end,
                      rsp_error_code, rsp_last};

   // forced receiver stall
   always @(posedge clock) begin
      if (hold_trigger) hold_cycles <= 400;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // result side: check each transaction, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(observed);
         rsp_ready <= (hold_cycles == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // one byte transaction, with random gaps before it
   task automatic send_item(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b, eos);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // stop sending and let every pending result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write while the scanner is idle
   task automatic write_marker(input logic [7:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {ssc_pkg::REG_COMMENT_MARKER, 2'b00};
      csr_pwdata  <= {24'h000000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.marker = value;
   endtask

   // append one byte to the chunk being built
   function automatic void append_byte(input logic [7:0] c);
      chunk_bytes = {chunk_bytes, c};
   endfunction

   function automatic void add_atom();
      logic [7:0] c;
      repeat ($urandom_range(1, 4)) begin
         do c = 8'($urandom_range(33, 126));
         while (c == ssc_pkg::CH_OPEN || c == ssc_pkg::CH_CLOSE ||
                c == ssc_pkg::CH_QUOTE || c == sb.marker);
         append_byte(c);
      end
   endfunction

   function automatic void add_blank();
      case ($urandom_range(5))
         0:       append_byte(ssc_pkg::CH_TAB);
         1:       append_byte(ssc_pkg::CH_NL);
         2:       append_byte(ssc_pkg::CH_VT);
         3:       append_byte(ssc_pkg::CH_FF);
         4:       append_byte(ssc_pkg::CH_CR);
         default: append_byte(ssc_pkg::CH_SPACE);
      endcase
   endfunction

   // well-formed text: atoms, strings with escapes, nested lists and comments
   function automatic void build_expr();
      int         open_lists;
      logic [7:0] c;
      open_lists = 0;
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(9))
            0, 1, 2: add_atom();
            3, 4: begin
               append_byte(ssc_pkg::CH_QUOTE);
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(2) == 0) begin
                     append_byte(ssc_pkg::CH_BSLASH);
                     case ($urandom_range(4))
                        0:       append_byte(ssc_pkg::CH_QUOTE);
                        1:       append_byte(ssc_pkg::CH_LOW_T);
                        2:       append_byte(ssc_pkg::CH_LOW_N);
                        3:       append_byte(ssc_pkg::CH_BSLASH);
                        default: append_byte(sb.marker);
                     endcase
                  end else begin
                     do c = 8'($urandom_range(32, 126));
                     while (c == ssc_pkg::CH_QUOTE || c == ssc_pkg::CH_BSLASH);
                     append_byte(c);
                  end
               end
               append_byte(ssc_pkg::CH_QUOTE);
            end
            5, 6: begin
               if (open_lists < 5) begin
                  append_byte(ssc_pkg::CH_OPEN);
                  open_lists++;
               end else begin
                  add_atom();
               end
            end
            7: begin
               if (open_lists > 0) begin
                  append_byte(ssc_pkg::CH_CLOSE);
                  open_lists--;
               end else begin
                  add_atom();
               end
            end
            8: begin
               append_byte(sb.marker);
               repeat ($urandom_range(0, 5)) begin
                  do c = 8'($urandom_range(255)); while (c == ssc_pkg::CH_NL);
                  append_byte(c);
               end
               append_byte(ssc_pkg::CH_NL);
            end
            default: add_blank();
         endcase
         if ($urandom_range(1) == 1) add_blank();
      end
      repeat (open_lists) append_byte(ssc_pkg::CH_CLOSE);
   endfunction

   // random chunks until enough bytes have been scanned outside the halted state
   task automatic run_block(input int useful_target);
      int         useful;
      int         kind;
      logic [7:0] c;
      useful = 0;
      while (useful < useful_target) begin
         chunk_bytes.delete();
         kind = $urandom_range(99);
         if (kind < 65) begin
            build_expr();
         end else if (kind < 85) begin
            // noise biased toward the special bytes
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(7))
                  0:       c = ssc_pkg::CH_OPEN;
                  1:       c = ssc_pkg::CH_CLOSE;
                  2:       c = ssc_pkg::CH_QUOTE;
                  3:       c = ssc_pkg::CH_BSLASH;
                  4:       c = sb.marker;
                  5:       c = ssc_pkg::CH_NL;
                  default: c = 8'($urandom_range(255));
               endcase
               append_byte(c);
            end
         end else begin
            // broken text: cut short and ended
            build_expr();
            chunk_bytes = chunk_bytes[0:$urandom_range(0, chunk_bytes.size() - 1)];
         end
         foreach (chunk_bytes[i]) begin
            if (!sb.halted) useful++;
            send_item(chunk_bytes[i], 1'b0);
         end
         if (kind >= 85 || sb.halted || $urandom_range(19) == 0) begin
            useful++;
            send_item(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   // stimulus
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases under the default marker
      send_idle_pct = 11;
      rsp_idle_pct  = 46;
      write_marker(ssc_pkg::MARKER_RESET);
      send_text("(a b)");
      send_text(";\n");
      send_text("\"\\\"\\t\\n\\;\\\\\"");
      send_text("\"\\q");
      send_text("z");
      send_item(8'h00, 1'b1);
      send_text(")");
      send_item(8'hff, 1'b1);
      send_text("(");
      send_item(8'h00, 1'b1);
      send_text("\"\\");
      send_item(8'hff, 1'b1);

      // random text across marker settings and idle mixes
      write_marker(8'h00);
      run_block(175);
      write_marker(8'hff);
      run_block(175);
      send_idle_pct = 46;
      rsp_idle_pct  = 11;
      write_marker(8'h23);
      run_block(175);
      write_marker(ssc_pkg::CH_QUOTE);
      run_block(175);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      write_marker(8'($urandom_range(255)));
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      run_block(175);
      write_marker(ssc_pkg::MARKER_RESET);
      run_block(175);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("scanned %0d byte transactions, checked %0d results, %0d expression ends",
               sb.bytes_seen, sb.results_seen, sb.expr_ends_seen);
      $display("errors raised: close %0d, escape %0d, unbalanced %0d, overflow %0d; depth %0d",
               sb.error_counts[ssc_pkg::ERR_EXTRA_CLOSE],
               sb.error_counts[ssc_pkg::ERR_BAD_ESCAPE],
               sb.error_counts[ssc_pkg::ERR_UNBALANCED],
               sb.error_counts[ssc_pkg::ERR_OVERFLOW], sb.deepest);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
